@@ rtl/calu_pkg.sv @@
// Types and operation codes for the flag-producing CPU ALU.
`timescale 1ns / 1ps

package calu_pkg;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic [3:0]  flags_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] result;
    logic [3:0]  flags_out;
  } out_item_t;

  // Flag positions in the packed Z N H C nibble
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // Operation codes
  localparam logic [4:0] OP_ADD   = 5'd0;
  localparam logic [4:0] OP_ADC   = 5'd1;
  localparam logic [4:0] OP_SUB   = 5'd2;
  localparam logic [4:0] OP_SBC   = 5'd3;
  localparam logic [4:0] OP_AND   = 5'd4;
  localparam logic [4:0] OP_XOR   = 5'd5;
  localparam logic [4:0] OP_OR    = 5'd6;
  localparam logic [4:0] OP_CP    = 5'd7;
  localparam logic [4:0] OP_INC   = 5'd8;
  localparam logic [4:0] OP_DEC   = 5'd9;
  localparam logic [4:0] OP_RLC   = 5'd10;
  localparam logic [4:0] OP_RRC   = 5'd11;
  localparam logic [4:0] OP_RL    = 5'd12;
  localparam logic [4:0] OP_RR    = 5'd13;
  localparam logic [4:0] OP_SLA   = 5'd14;
  localparam logic [4:0] OP_SRA   = 5'd15;
  localparam logic [4:0] OP_SWAP  = 5'd16;
  localparam logic [4:0] OP_SRL   = 5'd17;
  localparam logic [4:0] OP_BIT   = 5'd18;
  localparam logic [4:0] OP_RES   = 5'd19;
  localparam logic [4:0] OP_SET   = 5'd20;
  localparam logic [4:0] OP_RLCA  = 5'd21;
  localparam logic [4:0] OP_RRCA  = 5'd22;
  localparam logic [4:0] OP_RLA   = 5'd23;
  localparam logic [4:0] OP_RRA   = 5'd24;
  localparam logic [4:0] OP_CPL   = 5'd25;
  localparam logic [4:0] OP_SCF   = 5'd26;
  localparam logic [4:0] OP_CCF   = 5'd27;
  localparam logic [4:0] OP_ADD16 = 5'd28;
  localparam logic [4:0] OP_ADDSP = 5'd29;
  localparam logic [4:0] OP_INC16 = 5'd30;
  localparam logic [4:0] OP_DEC16 = 5'd31;

endpackage

@@ rtl/cpu_alu_with_flags_top.sv @@
// Top level of the flag-producing CPU ALU: input register, ALU, result register.
`timescale 1ns / 1ps

// Usage
//   Input channel in_valid / in_stall / in_data carries one operation per
//   transfer: kind, operand_a, operand_b, bit_index and flags_in (Z N H C).
//   Result channel out_valid / out_stall / out_data returns the 16-bit
//   result and the new flags, one result per input transfer, in order.
// Order: an accepted transfer lands in the input register; its result is then
//   taken into the result register when it can advance, shown with out_valid.
// Throughput: one operation per cycle, sustained, while out_stall is low.
//   The ALU is a single pass of byte/word add, subtract, rotate and bit logic
//   between the two registers, so nothing iterates.
// Stall: when out_stall holds the result register, the input register still
//   takes one more transfer if it is empty; in_stall rises only once both
//   registers are full, and all held contents stay stable.
// Reset: rst_n low (synchronous) empties both registers; out_valid is low
//   and in_stall is low right after reset. There is no other state.
module cpu_alu_with_flags_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  calu_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output calu_pkg::out_item_t out_data
);
  import calu_pkg::*;

  logic      op_vld_r;
  in_item_t  op_r;
  logic      res_vld_r;
  out_item_t res_r;
  out_item_t alu_res;
  logic      advance;
  logic      op_load;

  // Result register can take a new value when it is empty or being drained
  assign advance  = !res_vld_r || !out_stall;
  // Input register frees up when it is empty or moves on this cycle
  assign op_load  = !op_vld_r || advance;
  assign in_stall = !op_load;

  calu_alu u_alu (
    .op_i  (op_r),
    .res_o (alu_res)
  );

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_vld_r  <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      if (op_load) begin
        op_vld_r <= in_valid;
      end
      if (advance) begin
        res_vld_r <= op_vld_r;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (op_load && in_valid) begin
      op_r <= in_data;
    end
    if (advance && op_vld_r) begin
      res_r <= alu_res;
    end
  end

  assign out_valid = res_vld_r;
  assign out_data  = res_r;

endmodule

@@ rtl/calu_alu.sv @@
// Combinational datapath: one operation to result and Z N H C flags.
`timescale 1ns / 1ps

module calu_alu (
  input  calu_pkg::in_item_t  op_i,
  output calu_pkg::out_item_t res_o
);
  import calu_pkg::*;

  logic [7:0]  a, b;
  logic        cin;
  logic [7:0]  ax, as_;
  logic        aci;
  logic [8:0]  sum9;
  logic [4:0]  hsum5;
  logic [7:0]  sx, ss;
  logic        sci;
  logic [8:0]  dif9;
  logic [4:0]  hdif5;
  logic [7:0]  rot_v;
  logic [2:0]  rot_code;
  logic [7:0]  rot_r;
  logic        rot_c;
  logic        rot_acc;
  logic [16:0] w_sum17;
  logic [12:0] w_half13;
  logic [15:0] sp_sum;
  logic [8:0]  sp_c9;
  logic [4:0]  sp_h5;
  logic [7:0]  bmask;
  logic [15:0] r;
  logic [3:0]  f;

  assign a   = op_i.operand_a[7:0];
  assign b   = op_i.operand_b[7:0];
  assign cin = op_i.flags_in[FLAG_C];

  // Byte adder (add, adc, inc)
  assign ax    = (op_i.kind == OP_INC) ? b : a;
  assign as_   = (op_i.kind == OP_INC) ? 8'd1 : b;
  assign aci   = (op_i.kind == OP_ADC) ? cin : 1'b0;
  assign sum9  = {1'b0, ax} + {1'b0, as_} + {8'd0, aci};
  assign hsum5 = {1'b0, ax[3:0]} + {1'b0, as_[3:0]} + {4'd0, aci};

  // Byte subtractor (sub, sbc, cp, dec); bit above the top is the borrow
  assign sx    = (op_i.kind == OP_DEC) ? b : a;
  assign ss    = (op_i.kind == OP_DEC) ? 8'd1 : b;
  assign sci   = (op_i.kind == OP_SBC) ? cin : 1'b0;
  assign dif9  = {1'b0, sx} - {1'b0, ss} - {8'd0, sci};
  assign hdif5 = {1'b0, sx[3:0]} - {1'b0, ss[3:0]} - {4'd0, sci};

  // Shared rotate/shift unit; accumulator rotates map onto rlc/rrc/rl/rr
  assign rot_acc = (op_i.kind == OP_RLCA) || (op_i.kind == OP_RRCA) ||
                   (op_i.kind == OP_RLA)  || (op_i.kind == OP_RRA);
  assign rot_v   = rot_acc ? a : b;
  assign rot_code = rot_acc ? 3'(op_i.kind - OP_RLCA) : 3'(op_i.kind - OP_RLC);

  always_comb begin
    rot_r = 8'd0;
    rot_c = 1'b0;
    case (rot_code)
      3'd0: begin rot_c = rot_v[7]; rot_r = {rot_v[6:0], rot_v[7]}; end
      3'd1: begin rot_c = rot_v[0]; rot_r = {rot_v[0], rot_v[7:1]}; end
      3'd2: begin rot_c = rot_v[7]; rot_r = {rot_v[6:0], cin}; end
      3'd3: begin rot_c = rot_v[0]; rot_r = {cin, rot_v[7:1]}; end
      3'd4: begin rot_c = rot_v[7]; rot_r = {rot_v[6:0], 1'b0}; end
      3'd5: begin rot_c = rot_v[0]; rot_r = {rot_v[7], rot_v[7:1]}; end
      default: begin rot_c = rot_v[0]; rot_r = {1'b0, rot_v[7:1]}; end
    endcase
  end

  // Word adds
  assign w_sum17  = {1'b0, op_i.operand_a} + {1'b0, op_i.operand_b};
  assign w_half13 = {1'b0, op_i.operand_a[11:0]} + {1'b0, op_i.operand_b[11:0]};
  assign sp_sum   = op_i.operand_a + {{8{b[7]}}, b};
  assign sp_c9    = {1'b0, a} + {1'b0, b};
  assign sp_h5    = {1'b0, a[3:0]} + {1'b0, b[3:0]};

  assign bmask = 8'd1 << op_i.bit_index;

  always_comb begin
    r = 16'd0;
    f = op_i.flags_in;
    case (op_i.kind)
      OP_ADD, OP_ADC, OP_INC: begin
        r = {8'd0, sum9[7:0]};
        f = {(sum9[7:0] == 8'd0), 1'b0, hsum5[4],
             (op_i.kind == OP_INC) ? cin : sum9[8]};
      end
      OP_SUB, OP_SBC, OP_CP, OP_DEC: begin
        r = (op_i.kind == OP_CP) ? {8'd0, sx} : {8'd0, dif9[7:0]};
        f = {(dif9[7:0] == 8'd0), 1'b1, hdif5[4],
             (op_i.kind == OP_DEC) ? cin : dif9[8]};
      end
      OP_AND: begin
        r = {8'd0, a & b};
        f = {((a & b) == 8'd0), 1'b0, 1'b1, 1'b0};
      end
      OP_XOR: begin
        r = {8'd0, a ^ b};
        f = {((a ^ b) == 8'd0), 3'b000};
      end
      OP_OR: begin
        r = {8'd0, a | b};
        f = {((a | b) == 8'd0), 3'b000};
      end
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SRL: begin
        r = {8'd0, rot_r};
        f = {(rot_r == 8'd0), 2'b00, rot_c};
      end
      OP_SWAP: begin
        r = {8'd0, b[3:0], b[7:4]};
        f = {(b == 8'd0), 3'b000};
      end
      OP_BIT: begin
        r = {8'd0, b};
        f = {((b & bmask) == 8'd0), 1'b0, 1'b1, cin};
      end
      OP_RES: r = {8'd0, b & ~bmask};
      OP_SET: r = {8'd0, b | bmask};
      OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
        r = {8'd0, rot_r};
        f = {3'b000, rot_c};   // Z always cleared
      end
      OP_CPL: begin
        r = {8'd0, ~a};
        f = {op_i.flags_in[FLAG_Z], 1'b1, 1'b1, cin};
      end
      OP_SCF: begin
        r = {8'd0, a};
        f = {op_i.flags_in[FLAG_Z], 3'b001};
      end
      OP_CCF: begin
        r = {8'd0, a};
        f = {op_i.flags_in[FLAG_Z], 2'b00, ~cin};
      end
      OP_ADD16: begin
        r = w_sum17[15:0];
        f = {op_i.flags_in[FLAG_Z], 1'b0, w_half13[12], w_sum17[16]};
      end
      OP_ADDSP: begin
        r = sp_sum;
        f = {2'b00, sp_h5[4], sp_c9[8]};
      end
      OP_INC16: r = op_i.operand_b + 16'd1;
      default:  r = op_i.operand_b - 16'd1;   // dec16
    endcase
  end

  assign res_o.result    = r;
  assign res_o.flags_out = f;

endmodule

@@ bench/tb_cpu_alu_with_flags_top.sv @@
// Self-checking testbench for the flag-producing CPU ALU: directed edges, then random ops.
`timescale 1ns / 1ps

module tb_cpu_alu_with_flags_top;
  import calu_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 40000;  // slowest correct run is far below this
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned DRAIN_CYCLES = 4;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Results still owed by the ALU, oldest first.
  out_item_t   pending_results[$];
  bit          idle_en = 1'b1;   // random gaps/stalls on both channels
  int unsigned cycle_count = 0;
  int unsigned sent_count = 0;
  int unsigned checked_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned orphan_count = 0;
  bit [31:0]   kinds_seen = '0;

  cpu_alu_with_flags_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Byte rotate/shift selected by its CB opcode; returns {carry_out, value}.
  function automatic logic [8:0] shift_byte(input logic [4:0] sel, input logic [7:0] v,
                                            input logic ci);
    case (sel)
      OP_RLC:  return {v[7], v[6:0], v[7]};
      OP_RRC:  return {v[0], v[0], v[7:1]};
      OP_RL:   return {v[7], v[6:0], ci};
      OP_RR:   return {v[0], ci, v[7:1]};
      OP_SLA:  return {v[7], v[6:0], 1'b0};
      OP_SRA:  return {v[0], v[7], v[7:1]};  // sign bit stays put
      default: return {v[0], 1'b0, v[7:1]};  // SRL
    endcase
  endfunction

  // Expected result and flags of one ALU operation.
  function automatic out_item_t alu_expect(input in_item_t op);
    logic [7:0]  a, b, x, s, r8;
    logic [15:0] a16, b16;
    logic [8:0]  wide9;
    logic [4:0]  nib;
    logic [16:0] sum17;
    logic [12:0] sum13;
    logic [4:0]  sel;
    logic        cin, ci, c;
    logic [3:0]  f;
    out_item_t   res;
    a   = op.operand_a[7:0];
    b   = op.operand_b[7:0];
    a16 = op.operand_a;
    b16 = op.operand_b;
    cin = op.flags_in[FLAG_C];
    f   = op.flags_in;
    r8  = 8'h00;
    res.result = 16'h0000;
    case (op.kind)
      OP_ADD, OP_ADC, OP_INC: begin
        x  = (op.kind == OP_INC) ? b : a;
        s  = (op.kind == OP_INC) ? 8'h01 : b;
        ci = (op.kind == OP_ADC) ? cin : 1'b0;
        wide9 = {1'b0, x} + {1'b0, s} + {8'h00, ci};
        nib   = {1'b0, x[3:0]} + {1'b0, s[3:0]} + {4'h0, ci};
        r8 = wide9[7:0];
        f  = {(r8 == 8'h00), 1'b0, nib[4], (op.kind == OP_INC) ? cin : wide9[8]};
      end
      OP_SUB, OP_SBC, OP_CP, OP_DEC: begin
        // bit 8 / bit 4 of the difference are the borrows
        x  = (op.kind == OP_DEC) ? b : a;
        s  = (op.kind == OP_DEC) ? 8'h01 : b;
        ci = (op.kind == OP_SBC) ? cin : 1'b0;
        wide9 = {1'b0, x} - {1'b0, s} - {8'h00, ci};
        nib   = {1'b0, x[3:0]} - {1'b0, s[3:0]} - {4'h0, ci};
        f  = {(wide9[7:0] == 8'h00), 1'b1, nib[4], (op.kind == OP_DEC) ? cin : wide9[8]};
        r8 = (op.kind == OP_CP) ? x : wide9[7:0];
      end
      OP_AND: begin
        r8 = a & b;
        f  = {(r8 == 8'h00), 1'b0, 1'b1, 1'b0};
      end
      OP_XOR, OP_OR: begin
        r8 = (op.kind == OP_XOR) ? (a ^ b) : (a | b);
        f  = {(r8 == 8'h00), 3'b000};
      end
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SRL: begin
        {c, r8} = shift_byte(op.kind, b, cin);
        f = {(r8 == 8'h00), 2'b00, c};
      end
      OP_SWAP: begin
        r8 = {b[3:0], b[7:4]};
        f  = {(r8 == 8'h00), 3'b000};
      end
      OP_BIT: begin
        r8 = b;
        f  = {~b[op.bit_index], 1'b0, 1'b1, cin};
      end
      OP_RES: r8 = b & ~(8'h01 << op.bit_index);
      OP_SET: r8 = b | (8'h01 << op.bit_index);
      OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
        // same shifter as the CB forms, but Z is always cleared
        sel = op.kind - OP_RLCA + OP_RLC;
        {c, r8} = shift_byte(sel, a, cin);
        f = {3'b000, c};
      end
      OP_CPL: begin
        r8 = ~a;
        f  = {op.flags_in[FLAG_Z], 1'b1, 1'b1, cin};
      end
      OP_SCF: begin
        r8 = a;
        f  = {op.flags_in[FLAG_Z], 3'b001};
      end
      OP_CCF: begin
        r8 = a;
        f  = {op.flags_in[FLAG_Z], 2'b00, ~cin};
      end
      default: ;
    endcase
    res.result = {8'h00, r8};
    case (op.kind)
      OP_ADD16: begin
        sum17 = {1'b0, a16} + {1'b0, b16};
        sum13 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
        res.result = sum17[15:0];
        f = {op.flags_in[FLAG_Z], 1'b0, sum13[12], sum17[16]};
      end
      OP_ADDSP: begin
        // 16-bit sum with signed offset; flags from the unsigned low-byte add
        res.result = a16 + {{8{b[7]}}, b};
        wide9 = {1'b0, a} + {1'b0, b};
        nib   = {1'b0, a[3:0]} + {1'b0, b[3:0]};
        f = {2'b00, nib[4], wide9[8]};
      end
      OP_INC16: res.result = b16 + 16'h0001;
      OP_DEC16: res.result = b16 - 16'h0001;
      default: ;
    endcase
    res.flags_out = f;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers and result check
  // ---------------------------------------------------------------------------

  // Drive one operation; returns once its transfer has happened.
  task automatic send_op(input in_item_t op);
    @(negedge clk);
    while (idle_en && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(alu_expect(op));
    kinds_seen[op.kind] = 1'b1;
    sent_count++;
  endtask

  function automatic in_item_t make_op(input logic [4:0] k, input logic [15:0] a,
                                       input logic [15:0] b, input logic [2:0] bi,
                                       input logic [3:0] fl);
    return {k, a, b, bi, fl};
  endfunction

  // Operand values near the carry and borrow boundaries, or fully random.
  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return {8'($urandom_range(0, 255)), 8'h0f};
      3: return {8'($urandom_range(0, 255)), 8'h80};
      4: return {4'($urandom_range(0, 15)), 12'hfff};
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Receiver stalls at random while idling is enabled.
  always @(negedge clk) begin
    out_stall <= idle_en && ($urandom_range(0, 99) < 8);
  end

  // Compare every result transfer with the oldest owed result.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        orphan_count++;
        if (orphan_count + mismatch_count <= MAX_REPORTS)
          $display("[%0t] unexpected result transfer: result=%h flags=%b",
                   $realtime, out_data.result, out_data.flags_out);
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (out_data.result !== want.result || out_data.flags_out !== want.flags_out) begin
          mismatch_count++;
          if (orphan_count + mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch: result exp=%h got=%h, flags (ZNHC) exp=%b got=%b",
                     $realtime, want.result, out_data.result, want.flags_out,
                     out_data.flags_out);
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed",
               cycle_count, pending_results.size());
      $display("tb_cpu_alu_with_flags_top: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Byte add/sub/logic: carry and borrow out of bits 3 and 7, zero results,
  // carry-in on adc/sbc, inc/dec keeping C. Upper operand bytes are noise.
  task automatic test_byte_arith_edges();
    send_op(make_op(OP_ADD, 16'h12ff, 16'hab01, 3'd0, 4'h0));
    send_op(make_op(OP_ADC, 16'hff0f, 16'hff00, 3'd7, 4'h1));
    send_op(make_op(OP_SUB, 16'h0000, 16'h0001, 3'd0, 4'h0));
    send_op(make_op(OP_SBC, 16'h5510, 16'haa0f, 3'd0, 4'h1));
    send_op(make_op(OP_AND, 16'habf0, 16'h120f, 3'd0, 4'hf));
    send_op(make_op(OP_XOR, 16'h00ff, 16'hffff, 3'd0, 4'h0));
    send_op(make_op(OP_OR,  16'hff00, 16'hff00, 3'd0, 4'h0));
    send_op(make_op(OP_CP,  16'h0020, 16'h0090, 3'd0, 4'h0));
    send_op(make_op(OP_INC, 16'h0000, 16'h80ff, 3'd0, 4'h1));  // wraps to zero, C kept
    send_op(make_op(OP_DEC, 16'h0000, 16'h0000, 3'd0, 4'h0));  // borrow, C kept clear
  endtask

  // CB rotates and shifts, swap, bit/res/set at both ends of the byte, accumulator rotates, cpl, scf and ccf.
  task automatic test_shift_and_bit_edges();
    send_op(make_op(OP_RLC,  16'h0000, 16'h0080, 3'd0, 4'h0));
    send_op(make_op(OP_RRC,  16'h0000, 16'h0001, 3'd0, 4'h0));
    send_op(make_op(OP_RL,   16'h0000, 16'h0080, 3'd0, 4'h0));  // zero result, carry out
    send_op(make_op(OP_RR,   16'h0000, 16'h0001, 3'd0, 4'h1));  // carry enters bit 7
    send_op(make_op(OP_SLA,  16'h0000, 16'h0080, 3'd0, 4'h0));
    send_op(make_op(OP_SRA,  16'h0000, 16'h0081, 3'd0, 4'h0));
    send_op(make_op(OP_SWAP, 16'h0000, 16'hfff0, 3'd0, 4'hf));
    send_op(make_op(OP_SRL,  16'h0000, 16'h0001, 3'd0, 4'h0));
    send_op(make_op(OP_BIT,  16'h0000, 16'h007f, 3'd7, 4'h1));  // bit clear: Z set
    send_op(make_op(OP_BIT,  16'h0000, 16'h0080, 3'd7, 4'h8));
    send_op(make_op(OP_RES,  16'h0000, 16'hffff, 3'd0, 4'hf));
    send_op(make_op(OP_SET,  16'h0000, 16'hff00, 3'd7, 4'h0));
    send_op(make_op(OP_RLCA, 16'h0000, 16'h0000, 3'd0, 4'h8));  // Z cleared despite zero
    send_op(make_op(OP_RRCA, 16'hff01, 16'h0000, 3'd0, 4'h0));
    send_op(make_op(OP_RLA,  16'h0080, 16'h0000, 3'd0, 4'h1));
    send_op(make_op(OP_RRA,  16'h0001, 16'h0000, 3'd0, 4'h0));
    send_op(make_op(OP_CPL,  16'h0000, 16'h0000, 3'd0, 4'h9));
    send_op(make_op(OP_SCF,  16'h00aa, 16'h0000, 3'd0, 4'h6));
    send_op(make_op(OP_CCF,  16'h0055, 16'h0000, 3'd0, 4'h1));
  endtask

  // Word ops: carries out of bits 11 and 15, SP offset signs, 16-bit wrap.
  task automatic test_word_edges();
    send_op(make_op(OP_ADD16, 16'h0fff, 16'h0001, 3'd0, 4'h0));
    send_op(make_op(OP_ADD16, 16'hffff, 16'h0001, 3'd0, 4'h8));  // Z kept
    send_op(make_op(OP_ADDSP, 16'h00ff, 16'hff01, 3'd0, 4'hf));
    send_op(make_op(OP_ADDSP, 16'h0000, 16'h0080, 3'd0, 4'h0));  // most negative offset
    send_op(make_op(OP_INC16, 16'h0000, 16'hffff, 3'd0, 4'h5));
    send_op(make_op(OP_DEC16, 16'h0000, 16'h0000, 3'd0, 4'ha));
  endtask

  // Fully random operations with boundary-biased operands.
  task automatic test_random_ops(input int unsigned count);
    repeat (count)
      send_op(make_op(5'($urandom_range(0, 31)), pick_operand(), pick_operand(),
                      3'($urandom_range(0, 7)), 4'($urandom_range(0, 15))));
  endtask

  // Sustained one-per-cycle stream with no gaps or stalls on either side.
  task automatic test_back_to_back(input int unsigned count);
    idle_en = 1'b0;
    test_random_ops(count);
    idle_en = 1'b1;
  endtask

  // Random operations with operands drawn evenly over the full 16-bit range.
  task automatic test_uniform_operands(input int unsigned count);
    repeat (count)
      send_op(make_op(5'($urandom_range(0, 31)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), 3'($urandom_range(0, 7)),
                      4'($urandom_range(0, 15))));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_byte_arith_edges();
    test_shift_and_bit_edges();
    test_word_edges();
    test_random_ops(250);
    test_back_to_back(130);
    test_uniform_operands(120);

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain owed results, then give stray transfers a chance to show up.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d operations over %0d of 32 kinds; %0d results compared.",
             sent_count, $countones(kinds_seen), checked_count);
    $display("Mismatched results: %0d, unexpected results: %0d.",
             mismatch_count, orphan_count);
    if (mismatch_count == 0 && orphan_count == 0) begin
      $display("tb_cpu_alu_with_flags_top: PASS");
    end else begin
      $display("tb_cpu_alu_with_flags_top: FAIL");
    end
    $finish;
  end

endmodule
